// ===== rtl/fsfla_pkg.sv =====
// shared types, widths and codes for the fixed slot free list allocator
package fsfla_pkg;

	localparam int DEF_MAX_SLOTS = 1024;

	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int BYTES_W  = 13;
	localparam int OFFSET_W = 22;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 13;
	localparam int REG_W    = 1;

	localparam logic [BYTES_W-1:0] MIN_BYTES = 13'd8;
	localparam logic [BYTES_W-1:0] MAX_BYTES = 13'd4096;

	localparam logic [REG_W-1:0] REG_SLOT_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_SLOT_BYTES = 1'b1;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic              command;
		logic [SLOT_W-1:0] free_slot;
	} item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   granted_slot;
		logic [OFFSET_W-1:0] granted_offset;
		logic [COUNT_W-1:0]  in_use;
		logic [COUNT_W-1:0]  available;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic sweep;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic sweep_last;
	} stat_t;

endpackage

// ===== rtl/fsfla_ctrl.sv =====
// control state machine: idle, execute and list rebuild sweep
module fsfla_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       cfg_we,
	input  logic [fsfla_pkg::REG_W-1:0] cfg_index,
	input  fsfla_pkg::stat_t           stat,
	output fsfla_pkg::ctl_t            ctl,
	output logic                       busy,
	output logic                       done
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       done_q;
	logic       count_wr;

	assign count_wr = cfg_we && (cfg_index == fsfla_pkg::REG_SLOT_COUNT);

	always_comb begin
		state_nxt = state_q;
		if (count_wr) begin
			state_nxt = S_SWEEP;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_nxt = S_EXEC;
				end
				S_EXEC: begin
					state_nxt = S_IDLE;
				end
				S_SWEEP: begin
					if (stat.sweep_last) state_nxt = S_IDLE;
				end
				default: begin
					state_nxt = S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign ctl.load  = (state_q == S_IDLE) && start;
	assign ctl.exec  = (state_q == S_EXEC);
	assign ctl.sweep = (state_q == S_SWEEP);

	// an accepted beat is executed in the next cycle unless a slot_count write arrives with it
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load && !count_wr |=> ctl.exec)
		else $error("accepted beat not executed");

	// the result strobe is never raised while an item is executing
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !ctl.exec)
		else $error("result strobe overlaps execution");

endmodule

// ===== rtl/fsfla_dp.sv =====
// datapath: config registers, link memory, head and count registers, result register
module fsfla_dp #(
	parameter int MAX_SLOTS = fsfla_pkg::DEF_MAX_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fsfla_pkg::ctl_t             ctl,
	output fsfla_pkg::stat_t            stat,
	input  fsfla_pkg::item_t            item,
	input  logic                        cfg_we,
	input  logic [fsfla_pkg::REG_W-1:0] cfg_index,
	input  logic [fsfla_pkg::CFG_W-1:0] cfg_data,
	output fsfla_pkg::result_t          result
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int LINK_W = IDX_W + 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int PROD_W = IDX_W + fsfla_pkg::BYTES_W;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_SLOTS);

	logic [LINK_W-1:0]             mem [MAX_SLOTS];

	logic [CNT_W-1:0]              count_q;
	logic [fsfla_pkg::BYTES_W-1:0] bytes_q;
	logic [LINK_W-1:0]             head_q;
	logic [CNT_W-1:0]              used_q;
	logic [IDX_W-1:0]              sweep_q;

	logic                          cmd_s1;
	logic [fsfla_pkg::SLOT_W-1:0]  fslot_s1;
	logic [LINK_W-1:0]             rdata_s1;
	logic [PROD_W-1:0]             prod_s1;

	fsfla_pkg::result_t            res_q;
	fsfla_pkg::result_t            res_nxt;

	logic                          count_wr;
	logic                          bytes_wr;
	logic [fsfla_pkg::COUNT_W-1:0] cnt_raw;
	logic [CNT_W-1:0]              cnt_clamp;
	logic [fsfla_pkg::BYTES_W-1:0] bytes_clamp;
	logic [IDX_W-1:0]              head_idx;
	logic [IDX_W-1:0]              fidx;
	logic [LINK_W-1:0]             sweep_val;
	logic                          empty;
	logic                          in_range;
	logic                          push;
	logic [LINK_W-1:0]             head_nxt;
	logic [CNT_W-1:0]              used_nxt;
	logic [CNT_W-1:0]              avail_nxt;

	assign count_wr = cfg_we && (cfg_index == fsfla_pkg::REG_SLOT_COUNT);
	assign bytes_wr = cfg_we && (cfg_index == fsfla_pkg::REG_SLOT_BYTES);

	// clamp config writes into their legal ranges
	always_comb begin
		cnt_raw = cfg_data[fsfla_pkg::COUNT_W-1:0];
		if (cnt_raw == '0) begin
			cnt_clamp = CNT_W'(1);
		end else if (32'(cnt_raw) > MAX_SLOTS) begin
			cnt_clamp = CNT_W'(MAX_SLOTS);
		end else begin
			cnt_clamp = CNT_W'(cnt_raw);
		end
		if (cfg_data < fsfla_pkg::MIN_BYTES) begin
			bytes_clamp = fsfla_pkg::MIN_BYTES;
		end else if (cfg_data > fsfla_pkg::MAX_BYTES) begin
			bytes_clamp = fsfla_pkg::MAX_BYTES;
		end else begin
			bytes_clamp = cfg_data;
		end
	end

	assign head_idx  = head_q[IDX_W-1:0];
	assign fidx      = IDX_W'(fslot_s1);
	assign empty     = (32'(head_q) >= MAX_SLOTS);
	assign in_range  = (32'(fslot_s1) < 32'(count_q));
	assign push      = ctl.exec && (cmd_s1 == fsfla_pkg::CMD_FREE) && in_range;
	assign sweep_val = ((32'(sweep_q) + 1) < 32'(count_q)) ?
		LINK_W'(32'(sweep_q) + 1) : NULL_LINK;
	assign stat.sweep_last = (sweep_q == IDX_W'(MAX_SLOTS - 1));

	// next head, count and result for the executing beat
	always_comb begin
		head_nxt = head_q;
		used_nxt = used_q;
		res_nxt  = '0;
		if (cmd_s1 == fsfla_pkg::CMD_ALLOC) begin
			if (empty) begin
				res_nxt.status = fsfla_pkg::STAT_EMPTY;
			end else begin
				head_nxt = rdata_s1;
				if (used_q < count_q) used_nxt = used_q + CNT_W'(1);
				res_nxt.status         = fsfla_pkg::STAT_OK;
				res_nxt.granted_slot   = fsfla_pkg::SLOT_W'(head_idx);
				res_nxt.granted_offset = fsfla_pkg::OFFSET_W'(prod_s1);
			end
		end else begin
			if (!in_range) begin
				res_nxt.status = fsfla_pkg::STAT_RANGE;
			end else begin
				head_nxt = LINK_W'(fslot_s1);
				if (used_q != '0) used_nxt = used_q - CNT_W'(1);
				res_nxt.status = fsfla_pkg::STAT_OK;
			end
		end
		avail_nxt         = count_q - used_nxt;
		res_nxt.in_use    = fsfla_pkg::COUNT_W'(used_nxt);
		res_nxt.available = fsfla_pkg::COUNT_W'(avail_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(MAX_SLOTS);
			bytes_q <= fsfla_pkg::MIN_BYTES;
			head_q  <= '0;
			used_q  <= '0;
			sweep_q <= '0;
		end else begin
			if (bytes_wr) bytes_q <= bytes_clamp;
			if (count_wr) begin
				count_q <= cnt_clamp;
				head_q  <= '0;
				used_q  <= '0;
				sweep_q <= '0;
			end else begin
				if (ctl.sweep) sweep_q <= sweep_q + IDX_W'(1);
				if (ctl.exec) begin
					head_q <= head_nxt;
					used_q <= used_nxt;
				end
			end
		end
	end

	// accept stage: latch the beat, read the head link, form the byte offset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_s1   <= item.command;
			fslot_s1 <= item.free_slot;
			rdata_s1 <= mem[head_idx];
			prod_s1  <= PROD_W'(head_idx) * PROD_W'(bytes_q);
		end
	end

	// single write port shared by the rebuild sweep and by pushes
	always_ff @(posedge clk) begin
		if (ctl.sweep) begin
			mem[sweep_q] <= sweep_val;
		end else if (push) begin
			mem[fidx] <= head_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec) res_q <= res_nxt;
	end

	assign result = res_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= count_q)
		else $error("in-use count above slot count");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) <= MAX_SLOTS)
		else $error("head link beyond null");

	a_sweep_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.sweep && (ctl.exec || ctl.load)))
		else $error("item handled during rebuild sweep");

endmodule

// ===== rtl/fixed_slot_free_list_allocator.sv =====
// top level: LIFO free list allocator over a pool of fixed-size slots
// an accepted item runs through the execute state; done and result are registered as it ends
// a new item is accepted only while idle, not while one executes, as the head link is read synchronously
// reset and every slot_count write start a rebuild sweep over all MAX_SLOTS link entries with busy high
// reset is asynchronous active low; done is a one-cycle strobe and cannot be stalled
module fixed_slot_free_list_allocator #(
	parameter int MAX_SLOTS = fsfla_pkg::DEF_MAX_SLOTS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fsfla_pkg::item_t            item,
	output logic                        done,
	output fsfla_pkg::result_t          result,
	input  logic                        cfg_we,
	input  logic [fsfla_pkg::REG_W-1:0] cfg_index,
	input  logic [fsfla_pkg::CFG_W-1:0] cfg_data
);

	fsfla_pkg::ctl_t  ctl;
	fsfla_pkg::stat_t stat;

	fsfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.stat      (stat),
		.ctl       (ctl),
		.busy      (busy),
		.done      (done)
	);

	fsfla_dp #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule
